@@ rtl/rtcbcd_pkg.sv @@
// Shared types, constants and helper functions for the RTC BCD encoder.
`default_nettype none

package rtcbcd_pkg;

    localparam logic [11:0] BASE_YEAR   = 12'd2000;
    localparam logic [11:0] LAST_YEAR   = 12'd2099;
    localparam logic [7:0]  HALT_BIT    = 8'h80;
    localparam logic [7:0]  MODE12_BIT  = 8'h40;
    localparam logic [7:0]  PM_BIT      = 8'h20;
    localparam logic [5:0]  MAX_MIN_SEC = 6'd59;
    localparam logic [4:0]  MAX_HOUR12  = 5'd12;
    localparam logic [4:0]  MAX_HOUR24  = 5'd23;
    localparam logic [3:0]  MAX_MONTH   = 4'd12;

    localparam int IN_BITS   = 44;
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = 57;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    // Binary calendar time, last field (year) in the lowest bits.
    typedef struct packed {
        logic       halt_kept;
        logic       pm;
        logic       twelve_hour;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [2:0] weekday;
        logic [4:0] mday;
        logic [3:0] month;
        logic [11:0] year;
    } t_time;

    // Timekeeping register image, status in the lowest bit.
    typedef struct packed {
        logic [7:0] year_byte;
        logic [7:0] month_byte;
        logic [7:0] date_byte;
        logic [7:0] weekday_byte;
        logic [7:0] hours_byte;
        logic [7:0] minutes_byte;
        logic [7:0] seconds_byte;
        logic       status;
    } t_regs;

    // Binary to two-digit BCD for 0..99; tens digit by reciprocal multiply.
    function automatic logic [7:0] f_to_bcd(input logic [6:0] v);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  t10;
        logic [3:0]  ones;
        prod = v * 7'd103;
        tens = prod[13:10];
        t10  = {3'b000, tens} * 7'd10;
        ones = 4'(v - t10);
        return {tens, ones};
    endfunction

    // Days in a month; zero for month codes that mean nothing.
    function automatic logic [4:0] f_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rtcbcd_check.sv @@
// Range and calendar validation of one binary time record.
`default_nettype none

module rtcbcd_check (
    input  var rtcbcd_pkg::t_time i_time,
    output logic                  o_ok
);

    logic       yr_ok;
    logic       mon_ok;
    logic       date_ok;
    logic       hr_ok;
    logic       leap;
    logic [4:0] mlen;

    // Inside 2000..2099 the Gregorian rule reduces to divisible by four.
    assign leap   = (i_time.year[1:0] == 2'b00);
    assign mlen   = rtcbcd_pkg::f_month_len(i_time.month, leap);
    assign yr_ok  = (i_time.year >= rtcbcd_pkg::BASE_YEAR) &&
                    (i_time.year <= rtcbcd_pkg::LAST_YEAR);
    assign mon_ok = (i_time.month != 4'd0) && (i_time.month <= rtcbcd_pkg::MAX_MONTH);
    assign date_ok = (i_time.mday != 5'd0) && (i_time.mday <= mlen);

    always_comb begin
        if (i_time.twelve_hour) begin
            hr_ok = (i_time.hours != 5'd0) && (i_time.hours <= rtcbcd_pkg::MAX_HOUR12);
        end else begin
            hr_ok = (i_time.hours <= rtcbcd_pkg::MAX_HOUR24);
        end
    end

    assign o_ok = yr_ok && mon_ok && date_ok && hr_ok &&
                  (i_time.weekday != 3'd0) &&
                  (i_time.minutes <= rtcbcd_pkg::MAX_MIN_SEC) &&
                  (i_time.seconds <= rtcbcd_pkg::MAX_MIN_SEC);

endmodule

`default_nettype wire

@@ rtl/rtcbcd_pack.sv @@
// BCD packing of a checked time record into the seven register bytes.
`default_nettype none

module rtcbcd_pack (
    input  var rtcbcd_pkg::t_time i_time,
    input  logic                  i_ok,
    output rtcbcd_pkg::t_regs     o_regs
);

    logic [7:0] hrs_bcd;
    logic [7:0] pm_mask;

    assign hrs_bcd = rtcbcd_pkg::f_to_bcd({2'b00, i_time.hours});
    assign pm_mask = i_time.pm ? rtcbcd_pkg::PM_BIT : 8'h00;

    always_comb begin
        o_regs = '0;
        if (i_ok) begin
            o_regs.status       = 1'b0;
            o_regs.seconds_byte = rtcbcd_pkg::f_to_bcd({1'b0, i_time.seconds}) |
                                  (i_time.halt_kept ? rtcbcd_pkg::HALT_BIT : 8'h00);
            o_regs.minutes_byte = rtcbcd_pkg::f_to_bcd({1'b0, i_time.minutes});
            o_regs.hours_byte   = i_time.twelve_hour ?
                                  (rtcbcd_pkg::MODE12_BIT | pm_mask | hrs_bcd) : hrs_bcd;
            o_regs.weekday_byte = rtcbcd_pkg::f_to_bcd({4'b0000, i_time.weekday});
            o_regs.date_byte    = rtcbcd_pkg::f_to_bcd({2'b00, i_time.mday});
            o_regs.month_byte   = rtcbcd_pkg::f_to_bcd({3'b000, i_time.month});
            o_regs.year_byte    = rtcbcd_pkg::f_to_bcd(7'(i_time.year - rtcbcd_pkg::BASE_YEAR));
        end else begin
            o_regs.status = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rtc_time_bcd_encoder_top.sv @@
// Top level of the RTC calendar time to BCD register encoder.
//
//  channel  dir  beat contents                               handshake
//  s        in   one binary time record (tdata, 48 bits)     i_s_tvalid / o_s_tready
//  m        out  status + seven BCD register bytes (64 bits) o_m_tvalid / i_m_tready
//
//  A beat is captured in the input register, then the check and BCD
//  pack logic loads the result register.
//  Throughput is one beat per cycle while the sink keeps i_m_tready high.
//  When the result register is held, the input register holds too and
//  o_s_tready drops only if the input register is also full.
//  Synchronous active-low reset empties both stages.
`default_nettype none

module rtc_time_bcd_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // year[11:0] month[15:12] mday[20:16] weekday[23:21] hours[28:24]
    // minutes[34:29] seconds[40:35] twelve_hour[41] pm[42] halt_kept[43], zero pad
    input  logic [rtcbcd_pkg::IN_BYTES*8-1:0]  i_s_tdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // status[0] seconds_byte[8:1] minutes_byte[16:9] hours_byte[24:17]
    // weekday_byte[32:25] date_byte[40:33] month_byte[48:41] year_byte[56:49], zero pad
    output logic [rtcbcd_pkg::OUT_BYTES*8-1:0] o_m_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready
);

    // Input stage
    logic              r_s1_vld;
    logic              n_s1_vld;
    rtcbcd_pkg::t_time r_s1;
    // Result stage
    logic              r_out_vld;
    logic              n_out_vld;
    rtcbcd_pkg::t_regs r_out;
    rtcbcd_pkg::t_regs enc;

    logic s_acc;
    logic s1_move;
    logic ok;

    // Result register can take a new beat when empty or being drained.
    assign s1_move    = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || s1_move;
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign n_s1_vld  = s_acc || (r_s1_vld && !s1_move);
    assign n_out_vld = s1_move || (r_out_vld && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1 <= rtcbcd_pkg::t_time'(i_s_tdata[rtcbcd_pkg::IN_BITS-1:0]);
        end
        if (s1_move) begin
            r_out <= enc;
        end
    end

    rtcbcd_check u_check (
        .i_time (r_s1),
        .o_ok   (ok)
    );

    rtcbcd_pack u_pack (
        .i_time (r_s1),
        .i_ok   (ok),
        .o_regs (enc)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(rtcbcd_pkg::OUT_BYTES*8-rtcbcd_pkg::OUT_BITS){1'b0}}, r_out};

    // An invalid record carries all-zero bytes, halt bit included.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status) |-> (r_out[rtcbcd_pkg::OUT_BITS-1:1] == '0))
        else $error("invalid result has nonzero bytes");

    // A valid year byte always holds two decimal digits.
    a_year_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.status) |-> (r_out.year_byte[7:4] <= 4'd9 &&
                                          r_out.year_byte[3:0] <= 4'd9))
        else $error("year byte not BCD");

    // Minutes never set the top bit; hours never set bit 7.
    a_top_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (!r_out.minutes_byte[7] && !r_out.hours_byte[7]))
        else $error("reserved bit set in result");

    // A held input stage keeps its record while the result side stalls.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_move) |=> (r_s1_vld && $stable(r_s1)))
        else $error("input stage lost a stalled beat");

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> (r_out_vld && $stable(r_out)))
        else $error("result register changed while stalled");

endmodule

`default_nettype wire
